// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of the deque core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define DQ_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deque assertion failed");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define DQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deque assertion failed");

`endif

// ===== rtl/core/dq_pkg.sv =====
// Package with the types and constants of the deque core.
package dq_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 2'd0,
    CMD_PUSH_FRONT = 2'd1,
    CMD_POP_BACK   = 2'd2,
    CMD_POP_FRONT  = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic shift_right;
    logic shift_left;
    logic push_back;
    logic pop_back;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/dq_cmd_if.sv =====
// Command channel interface of the deque core.
interface dq_cmd_if
  import dq_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [WORD_W-1:0] push_value;

  modport source (output valid, output command, output push_value, input ready);
  modport sink (input valid, input command, input push_value, output ready);
endinterface

// ===== rtl/core/dq_rsp_if.sv =====
// Response channel interface of the deque core.
interface dq_rsp_if
  import dq_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   pop_value;
  logic [STATUS_W-1:0] status;
  logic                is_empty;
  logic                is_full;

  modport source (output valid, output pop_value, output status, output is_empty,
                  output is_full, input ready);
  modport sink (input valid, input pop_value, input status, input is_empty,
                input is_full, output ready);
endinterface

// ===== rtl/core/dq_cell.sv =====
// One storage cell of the deque chain, holding the entry at its position.
module dq_cell
  import dq_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cell_ctrl_t            ctrl_i,
  input  logic                  left_valid_i,
  input  logic [DATA_WIDTH-1:0] left_data_i,
  input  logic                  right_valid_i,
  input  logic [DATA_WIDTH-1:0] right_data_i,
  input  logic [DATA_WIDTH-1:0] push_data_i,
  output logic                  valid_o,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  last_o
);

  logic                  valid_q, valid_d;
  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  data_we;

  assign last_o  = valid_q & ~right_valid_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    data_we = 1'b0;
    if (ctrl_i.shift_right) begin
      valid_d = left_valid_i;
      data_d  = left_data_i;
      data_we = 1'b1;
    end else if (ctrl_i.shift_left) begin
      valid_d = right_valid_i;
      data_d  = right_data_i;
      data_we = 1'b1;
    end else if (ctrl_i.push_back && !valid_q && left_valid_i) begin
      valid_d = 1'b1;
      data_d  = push_data_i;
      data_we = 1'b1;
    end else if (ctrl_i.pop_back && last_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_we) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== rtl/core/double_ended_queue_core.sv =====
// Top level of the deque core: a row of shifting cells and a response register.
// Response: registered, and appears in the cycle after the command is taken.
// Throughput: one command per cycle while the response is taken; an untaken response stalls commands.
// Reset: all cells read as empty and no response is pending; no clearing pass is needed.
module double_ended_queue_core
  import dq_pkg::*;
#(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  dq_cmd_if.sink   cmd_i,
  dq_rsp_if.source rsp_o
);

  logic                  cell_valid [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_data  [CAPACITY];
  logic                  cell_last  [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_tap   [CAPACITY];

  logic [DATA_WIDTH-1:0] push_word;
  logic [DATA_WIDTH-1:0] back_word;
  logic [DATA_WIDTH-1:0] sel_word;
  logic [WORD_W-1:0]     sel_word_ext;

  cell_ctrl_t ctrl;
  cmd_e       cmd;
  logic       accept;
  logic       empty_now, full_now;
  logic       is_pop;

  logic                rsp_valid_q;
  logic [WORD_W-1:0]   pop_value_q, pop_value_d;
  status_e             status_q, status_d;
  logic                is_empty_q, is_empty_d;
  logic                is_full_q, is_full_d;

  assign cmd       = cmd_e'(cmd_i.command);
  assign accept    = cmd_i.valid & cmd_i.ready;
  assign empty_now = ~cell_valid[0];
  assign full_now  = cell_valid[CAPACITY-1];
  assign is_pop    = (cmd == CMD_POP_BACK) || (cmd == CMD_POP_FRONT);

  assign cmd_i.ready = ~rsp_valid_q | rsp_o.ready;

  if (DATA_WIDTH >= WORD_W) begin : g_wide
    assign push_word    = DATA_WIDTH'(cmd_i.push_value);
    assign sel_word_ext = sel_word[WORD_W-1:0];
  end else begin : g_narrow
    assign push_word    = cmd_i.push_value[DATA_WIDTH-1:0];
    assign sel_word_ext = WORD_W'(sel_word);
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                  left_valid, right_valid;
    logic [DATA_WIDTH-1:0] left_data, right_data;

    if (i == 0) begin : g_head
      assign left_valid = 1'b1;
      assign left_data  = push_word;
    end else begin : g_body
      assign left_valid = cell_valid[i-1];
      assign left_data  = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_valid = 1'b0;
      assign right_data  = '0;
    end else begin : g_inner
      assign right_valid = cell_valid[i+1];
      assign right_data  = cell_data[i+1];
    end

    dq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .left_valid_i (left_valid),
      .left_data_i  (left_data),
      .right_valid_i(right_valid),
      .right_data_i (right_data),
      .push_data_i  (push_word),
      .valid_o      (cell_valid[i]),
      .data_o       (cell_data[i]),
      .last_o       (cell_last[i])
    );

    assign cell_tap[i] = cell_last[i] ? cell_data[i] : '0;
  end

  always_comb begin
    back_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      back_word = back_word | cell_tap[i];
    end
  end

  always_comb begin
    ctrl        = '0;
    sel_word    = '0;
    status_d    = ST_OK;
    unique case (cmd)
      CMD_PUSH_BACK: begin
        ctrl.push_back = accept & ~full_now;
        if (full_now) status_d = ST_OVERFLOW;
      end
      CMD_PUSH_FRONT: begin
        ctrl.shift_right = accept & ~full_now;
        if (full_now) status_d = ST_OVERFLOW;
      end
      CMD_POP_BACK: begin
        ctrl.pop_back = accept & ~empty_now;
        sel_word      = back_word;
        if (empty_now) status_d = ST_UNDERFLOW;
      end
      CMD_POP_FRONT: begin
        ctrl.shift_left = accept & ~empty_now;
        sel_word        = cell_data[0];
        if (empty_now) status_d = ST_UNDERFLOW;
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
    pop_value_d = (is_pop && !empty_now) ? sel_word_ext : '0;
    is_empty_d  = is_pop ? ~cell_valid[1] : 1'b0;
    is_full_d   = is_pop ? 1'b0 : cell_valid[CAPACITY-2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      rsp_valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pop_value_q <= pop_value_d;
      status_q    <= status_d;
      is_empty_q  <= is_empty_d;
      is_full_q   <= is_full_d;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.pop_value = pop_value_q;
  assign rsp_o.status    = status_q;
  assign rsp_o.is_empty  = is_empty_q;
  assign rsp_o.is_full   = is_full_q;

endmodule

// ===== rtl/core/dq_checker.sv =====
// Port-level checker of the deque core and its binding to the top level.
`include "assert_macros.svh"

module dq_checker
  import dq_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [WORD_W-1:0]   pop_value_i,
  input logic [STATUS_W-1:0] status_i,
  input logic                is_empty_i,
  input logic                is_full_i
);

  `DQ_ASSERT(a_flags_exclusive, rsp_valid_i, !(is_empty_i && is_full_i))
  `DQ_ASSERT(a_underflow_empty, rsp_valid_i && status_i == ST_UNDERFLOW,
             is_empty_i && pop_value_i == '0)
  `DQ_ASSERT(a_overflow_full, rsp_valid_i && status_i == ST_OVERFLOW,
             is_full_i && pop_value_i == '0)
  `DQ_ASSERT(a_status_code, rsp_valid_i,
             status_i == ST_OK || status_i == ST_OVERFLOW || status_i == ST_UNDERFLOW)
  `DQ_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i,
                  rsp_valid_i && $stable(pop_value_i) && $stable(status_i))

endmodule

bind double_ended_queue_core dq_checker u_dq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .rsp_valid_i(rsp_o.valid),
  .rsp_ready_i(rsp_o.ready),
  .pop_value_i(rsp_o.pop_value),
  .status_i   (rsp_o.status),
  .is_empty_i (rsp_o.is_empty),
  .is_full_i  (rsp_o.is_full)
);

// ===== sim/tb_top.sv =====
// Testbench for the deque core: directed and random command streams, checked by a predictor.
`timescale 1ns / 1ps

module tb_top;
  import dq_pkg::*;

  localparam int DEPTH = 64;

  typedef struct {
    logic [WORD_W-1:0] pop_value;
    status_e           status;
    logic              is_empty;
    logic              is_full;
  } deque_result_t;

  logic clk;
  logic rst_n;

  dq_cmd_if cmd_bus ();
  dq_rsp_if rsp_bus ();

  double_ended_queue_core #(
    .CAPACITY  (DEPTH),
    .DATA_WIDTH(WORD_W)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cmd_i (cmd_bus),
    .rsp_o (rsp_bus)
  );

  logic [WORD_W-1:0] shadow_slots [DEPTH];
  int                shadow_front;
  int                shadow_back;
  int                shadow_count;
  deque_result_t     pending_results [$];
  int                mismatch_count;
  bit                idle_on;
  bit                stall_on;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic deque_result_t deque_predict(cmd_e op, logic [WORD_W-1:0] word);
    deque_result_t res;
    res.pop_value = '0;
    res.status    = ST_OK;
    case (op)
      CMD_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          res.status = ST_OVERFLOW;
        end else begin
          shadow_slots[shadow_back] = word;
          shadow_back = (shadow_back == DEPTH - 1) ? 0 : shadow_back + 1;
          shadow_count++;
        end
      end
      CMD_PUSH_FRONT: begin
        if (shadow_count >= DEPTH) begin
          res.status = ST_OVERFLOW;
        end else begin
          shadow_front = (shadow_front == 0) ? DEPTH - 1 : shadow_front - 1;
          shadow_slots[shadow_front] = word;
          shadow_count++;
        end
      end
      CMD_POP_BACK: begin
        if (shadow_count == 0) begin
          res.status = ST_UNDERFLOW;
        end else begin
          shadow_back = (shadow_back == 0) ? DEPTH - 1 : shadow_back - 1;
          res.pop_value = shadow_slots[shadow_back];
          shadow_count--;
        end
      end
      default: begin
        if (shadow_count == 0) begin
          res.status = ST_UNDERFLOW;
        end else begin
          res.pop_value = shadow_slots[shadow_front];
          shadow_front = (shadow_front == DEPTH - 1) ? 0 : shadow_front + 1;
          shadow_count--;
        end
      end
    endcase
    res.is_empty = (shadow_count == 0);
    res.is_full  = (shadow_count >= DEPTH);
    return res;
  endfunction

  task automatic send_command(input cmd_e op, input logic [WORD_W-1:0] word);
    int gap;
    cmd_bus.valid      <= 1'b1;
    cmd_bus.command    <= op;
    cmd_bus.push_value <= word;
    do @(posedge clk); while (!cmd_bus.ready);
    pending_results.push_back(deque_predict(op, word));
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    cmd_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic cmd_e pick_command(int push_pct);
    if ($urandom_range(0, 99) < push_pct) begin
      return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
    end
    return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
  endfunction

  task automatic test_directed();
    send_command(CMD_POP_BACK, 32'hFFFF_FFFF);
    send_command(CMD_POP_FRONT, 32'h0000_0000);
    send_command(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    send_command(CMD_PUSH_BACK, 32'h0000_0000);
    send_command(CMD_PUSH_FRONT, 32'hAAAA_AAAA);
    send_command(CMD_PUSH_BACK, 32'h5555_5555);
    send_command(CMD_POP_FRONT, 32'hFFFF_FFFF);
    send_command(CMD_POP_BACK, 32'h1234_5678);
    send_command(CMD_POP_BACK, 32'h0);
    send_command(CMD_POP_FRONT, 32'h0);
    send_command(CMD_POP_FRONT, 32'h0);
    send_command(CMD_PUSH_BACK, 32'h8000_0001);
    send_command(CMD_POP_FRONT, 32'h0);
    send_command(CMD_PUSH_FRONT, 32'h7FFF_FFFE);
    send_command(CMD_POP_BACK, 32'h0);
    send_command(CMD_POP_BACK, 32'h0);
  endtask

  task automatic test_fill_and_overflow();
    for (int i = 0; i < DEPTH + 4; i++) begin
      send_command($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, $urandom);
    end
    for (int i = 0; i < DEPTH + 3; i++) begin
      send_command($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK, $urandom);
    end
  endtask

  task automatic test_random_walk(input int n_items, input int push_pct);
    for (int i = 0; i < n_items; i++) begin
      send_command(pick_command(push_pct), $urandom);
    end
  endtask

  always @(posedge clk) begin
    deque_result_t want;
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result: pop_value %h status %0d", rsp_bus.pop_value,
                   rsp_bus.status);
        end
      end else begin
        want = pending_results.pop_front();
        if (rsp_bus.pop_value !== want.pop_value || rsp_bus.status !== want.status ||
            rsp_bus.is_empty !== want.is_empty || rsp_bus.is_full !== want.is_full) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: pop_value exp %h got %h, status exp %0d got %0d",
                     want.pop_value, rsp_bus.pop_value, want.status, rsp_bus.status);
            $display("  is_empty exp %b got %b, is_full exp %b got %b",
                     want.is_empty, rsp_bus.is_empty, want.is_full, rsp_bus.is_full);
          end
        end
      end
    end
  end

  initial begin
    int stall_left;
    stall_left = 0;
    rsp_bus.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        rsp_bus.ready <= 1'b0;
      end else if (stall_on && $urandom_range(0, 99) < 30) begin
        stall_left = pick_gap();
        rsp_bus.ready <= (stall_left == 0);
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    mismatch_count = 0;
    shadow_front   = 0;
    shadow_back    = 0;
    shadow_count   = 0;
    idle_on        = 1'b1;
    stall_on       = 1'b1;
    rst_n              <= 1'b0;
    cmd_bus.valid      <= 1'b0;
    cmd_bus.command    <= CMD_PUSH_BACK;
    cmd_bus.push_value <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    wait_for_results();
    test_fill_and_overflow();
    idle_on  = 1'b0;
    stall_on = 1'b0;
    test_fill_and_overflow();
    idle_on  = 1'b1;
    stall_on = 1'b1;
    test_random_walk(200, 70);
    test_random_walk(200, 30);
    wait_for_results();
    idle_on = 1'b0;
    test_random_walk(150, 55);
    idle_on  = 1'b1;
    stall_on = 1'b0;
    test_random_walk(120, 80);
    stall_on = 1'b1;
    test_random_walk(120, 50);
    wait_for_results();
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
